// ----- src/cavpid_pkg.sv -----
// Shared types, constants and arithmetic helpers for the cascaded angle/velocity PID.
package cavpid_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LIM_WIDTH  = DATA_WIDTH - 1;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int RND_WIDTH  = PROD_WIDTH - FRAC_BITS;
  localparam int CFG_IDX_W  = 3;
  // derivative scale 500 = 512 - 8 - 4
  localparam int DSC_SH0    = 9;
  localparam int DSC_SH1    = 3;
  localparam int DSC_SH2    = 2;
  localparam int DSC_WIDTH  = DATA_WIDTH + DSC_SH0 + 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [LIM_WIDTH-1:0]  lim_t;

  localparam data_t VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_KP       = 3'd0,
    REG_ANGLE_KD       = 3'd1,
    REG_VEL_KP         = 3'd2,
    REG_VEL_KI         = 3'd3,
    REG_VEL_KD         = 3'd4,
    REG_TARGET_ANGLE   = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_OUTPUT_LIMIT   = 3'd7
  } reg_idx_t;

  localparam data_t RST_ANGLE_KP     = 32'sd131072;
  localparam data_t RST_ANGLE_KD     = 32'sd0;
  localparam data_t RST_VEL_KP       = 32'sd32768;
  localparam data_t RST_VEL_KI       = 32'sd0;
  localparam data_t RST_VEL_KD       = 32'sd3277;
  localparam data_t RST_TARGET_ANGLE = 32'sd308831;
  localparam lim_t  RST_INT_LIMIT    = 31'd655360;
  localparam lim_t  RST_OUT_LIMIT    = 31'd327680;

  typedef struct packed {
    data_t angle_kp;
    data_t angle_kd;
    data_t vel_kp;
    data_t vel_ki;
    data_t vel_kd;
    data_t target_angle;
    lim_t  integral_limit;
    lim_t  output_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AE,
    ST_RATE_A,
    ST_M2,
    ST_VT0,
    ST_VT1,
    ST_VE,
    ST_RATE_V,
    ST_M4,
    ST_M5,
    ST_VI,
    ST_ADDVI,
    ST_ADDD,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_KPA,
    MS_KDA,
    MS_KPV,
    MS_KIV,
    MS_KDV
  } mul_sel_t;

  typedef enum logic [3:0] {
    AO_NONE,
    AO_AE,
    AO_RATE_A,
    AO_ACC_LD,
    AO_ACC_ADD,
    AO_VE,
    AO_RATE_V,
    AO_VI,
    AO_ADD_VI,
    AO_OUT
  } alu_op_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     rnd_en;
    alu_op_t  alu_op;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  function automatic data_t sat_wide(input logic signed [DATA_WIDTH:0] v);
    data_t r;
    if (v > $signed({VMAX[DATA_WIDTH-1], VMAX})) r = VMAX;
    else if (v < $signed({VMIN[DATA_WIDTH-1], VMIN})) r = VMIN;
    else r = v[DATA_WIDTH-1:0];
    return r;
  endfunction

  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    s = $signed({a[DATA_WIDTH-1], a}) + $signed({b[DATA_WIDTH-1], b});
    return sat_wide(s);
  endfunction

  function automatic data_t sat_sub(input data_t a, input data_t b);
    logic signed [DATA_WIDTH:0] s;
    s = $signed({a[DATA_WIDTH-1], a}) - $signed({b[DATA_WIDTH-1], b});
    return sat_wide(s);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] mag(input data_t v);
    logic [DATA_WIDTH-1:0] r;
    if (v[DATA_WIDTH-1]) r = DATA_WIDTH'(-v);
    else r = v;
    return r;
  endfunction

  // difference times the tick rate, both steps saturating
  function automatic data_t scaled_rate(input data_t e, input data_t last);
    data_t                      d;
    logic signed [DSC_WIDTH-1:0] dx;
    logic signed [DSC_WIDTH-1:0] m;
    data_t                      r;
    d  = sat_sub(e, last);
    dx = DSC_WIDTH'(d);
    m  = (dx <<< DSC_SH0) - (dx <<< DSC_SH1) - (dx <<< DSC_SH2);
    if (m > DSC_WIDTH'(VMAX)) r = VMAX;
    else if (m < DSC_WIDTH'(VMIN)) r = VMIN;
    else r = m[DATA_WIDTH-1:0];
    return r;
  endfunction

  // round magnitude half away from zero, apply sign, saturate
  function automatic data_t qround(input logic [PROD_WIDTH-1:0] p, input logic neg);
    logic [PROD_WIDTH-1:0] pr;
    logic [RND_WIDTH-1:0]  r;
    logic [RND_WIDTH-1:0]  lim;
    data_t                 res;
    pr  = p + (PROD_WIDTH'(1) << (FRAC_BITS - 1));
    r   = pr[PROD_WIDTH-1:FRAC_BITS];
    lim = neg ? RND_WIDTH'(VMAX) + RND_WIDTH'(1) : RND_WIDTH'(VMAX);
    if (r > lim) r = lim;
    if (neg) res = DATA_WIDTH'(-r);
    else res = r[DATA_WIDTH-1:0];
    return res;
  endfunction

  function automatic data_t clampsym(input data_t v, input lim_t lim);
    data_t l;
    data_t r;
    l = $signed({1'b0, lim});
    if (v > l) r = l;
    else if (v < -l) r = -l;
    else r = v;
    return r;
  endfunction

endpackage

// ----- src/cavpid_ctrl.sv -----
// Sequencer that steps the shared multiplier and ALU through one control tick.
module cavpid_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cavpid_pkg::sts_t      sts,
  output cavpid_pkg::cmd_t      cmd,
  output cavpid_pkg::state_t    state
);

  cavpid_pkg::state_t state_r;
  cavpid_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cavpid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cavpid_pkg::ST_IDLE:    if (in_valid) state_nxt = cavpid_pkg::ST_AE;
      cavpid_pkg::ST_AE:      state_nxt = cavpid_pkg::ST_RATE_A;
      cavpid_pkg::ST_RATE_A:  state_nxt = cavpid_pkg::ST_M2;
      cavpid_pkg::ST_M2:      state_nxt = cavpid_pkg::ST_VT0;
      cavpid_pkg::ST_VT0:     state_nxt = cavpid_pkg::ST_VT1;
      cavpid_pkg::ST_VT1:     state_nxt = cavpid_pkg::ST_VE;
      cavpid_pkg::ST_VE:      state_nxt = cavpid_pkg::ST_RATE_V;
      cavpid_pkg::ST_RATE_V:  state_nxt = cavpid_pkg::ST_M4;
      cavpid_pkg::ST_M4:      state_nxt = cavpid_pkg::ST_M5;
      cavpid_pkg::ST_M5:      state_nxt = cavpid_pkg::ST_VI;
      cavpid_pkg::ST_VI:      state_nxt = cavpid_pkg::ST_ADDVI;
      cavpid_pkg::ST_ADDVI:   state_nxt = cavpid_pkg::ST_ADDD;
      cavpid_pkg::ST_ADDD:    state_nxt = cavpid_pkg::ST_OUT;
      cavpid_pkg::ST_OUT:     if (!sts.out_full) state_nxt = cavpid_pkg::ST_IDLE;
      default:                state_nxt = cavpid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = cavpid_pkg::MS_KPA;
    cmd.alu_op   = cavpid_pkg::AO_NONE;
    unique case (state_r)
      cavpid_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      cavpid_pkg::ST_AE: begin
        cmd.alu_op = cavpid_pkg::AO_AE;
      end
      cavpid_pkg::ST_RATE_A: begin
        cmd.alu_op  = cavpid_pkg::AO_RATE_A;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cavpid_pkg::MS_KPA;
      end
      cavpid_pkg::ST_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cavpid_pkg::MS_KDA;
        cmd.rnd_en  = 1'b1;
      end
      cavpid_pkg::ST_VT0: begin
        cmd.rnd_en = 1'b1;
        cmd.alu_op = cavpid_pkg::AO_ACC_LD;
      end
      cavpid_pkg::ST_VT1: begin
        cmd.alu_op = cavpid_pkg::AO_ACC_ADD;
      end
      cavpid_pkg::ST_VE: begin
        cmd.alu_op = cavpid_pkg::AO_VE;
      end
      cavpid_pkg::ST_RATE_V: begin
        cmd.alu_op  = cavpid_pkg::AO_RATE_V;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cavpid_pkg::MS_KPV;
      end
      cavpid_pkg::ST_M4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cavpid_pkg::MS_KIV;
        cmd.rnd_en  = 1'b1;
      end
      cavpid_pkg::ST_M5: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cavpid_pkg::MS_KDV;
        cmd.rnd_en  = 1'b1;
        cmd.alu_op  = cavpid_pkg::AO_ACC_LD;
      end
      cavpid_pkg::ST_VI: begin
        cmd.rnd_en = 1'b1;
        cmd.alu_op = cavpid_pkg::AO_VI;
      end
      cavpid_pkg::ST_ADDVI: begin
        cmd.alu_op = cavpid_pkg::AO_ADD_VI;
      end
      cavpid_pkg::ST_ADDD: begin
        cmd.alu_op = cavpid_pkg::AO_ACC_ADD;
      end
      cavpid_pkg::ST_OUT: begin
        if (!sts.out_full) begin
          cmd.alu_op   = cavpid_pkg::AO_OUT;
          cmd.out_load = 1'b1;
        end
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  assign in_stall = (state_r != cavpid_pkg::ST_IDLE);
  assign state    = state_r;

endmodule

// ----- src/cavpid_dp.sv -----
// Datapath: shared 32x32 multiplier, rounding stage, saturating ALU and result register.
module cavpid_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cavpid_pkg::cmd_t                   cmd,
  output cavpid_pkg::sts_t                   sts,
  input  cavpid_pkg::cfg_t                   cfg,
  input  logic signed [cavpid_pkg::DATA_WIDTH-1:0] in_measured_angle,
  input  logic signed [cavpid_pkg::DATA_WIDTH-1:0] in_measured_velocity,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cavpid_pkg::DATA_WIDTH-1:0] out_torque_command
);

  cavpid_pkg::data_t ang_r, ang_nxt;
  cavpid_pkg::data_t vel_r, vel_nxt;
  cavpid_pkg::data_t ae_r, ae_nxt;
  cavpid_pkg::data_t ve_r, ve_nxt;
  cavpid_pkg::data_t rate_r, rate_nxt;
  cavpid_pkg::data_t acc_r, acc_nxt;
  cavpid_pkg::data_t q_r, q_nxt;
  cavpid_pkg::data_t out_r, out_nxt;
  cavpid_pkg::data_t prev_ae_r, prev_ae_nxt;
  cavpid_pkg::data_t prev_ve_r, prev_ve_nxt;
  cavpid_pkg::data_t vi_r, vi_nxt;
  logic [cavpid_pkg::PROD_WIDTH-1:0] prod_r, prod_nxt;
  logic                              neg_r, neg_nxt;
  logic                              out_valid_r, out_valid_nxt;

  cavpid_pkg::data_t mul_a;
  cavpid_pkg::data_t mul_b;

  always_comb begin
    unique case (cmd.mul_sel)
      cavpid_pkg::MS_KPA: begin mul_a = cfg.angle_kp; mul_b = ae_r;   end
      cavpid_pkg::MS_KDA: begin mul_a = cfg.angle_kd; mul_b = rate_r; end
      cavpid_pkg::MS_KPV: begin mul_a = cfg.vel_kp;   mul_b = ve_r;   end
      cavpid_pkg::MS_KIV: begin mul_a = cfg.vel_ki;   mul_b = ve_r;   end
      cavpid_pkg::MS_KDV: begin mul_a = cfg.vel_kd;   mul_b = rate_r; end
      default:            begin mul_a = cfg.angle_kp; mul_b = ae_r;   end
    endcase
  end

  always_comb begin
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    if (cmd.mul_en) begin
      prod_nxt = cavpid_pkg::PROD_WIDTH'(cavpid_pkg::mag(mul_a))
               * cavpid_pkg::PROD_WIDTH'(cavpid_pkg::mag(mul_b));
      neg_nxt  = mul_a[cavpid_pkg::DATA_WIDTH-1] ^ mul_b[cavpid_pkg::DATA_WIDTH-1];
    end
    if (cmd.rnd_en) begin
      q_nxt = cavpid_pkg::qround(prod_r, neg_r);
    end
  end

  always_comb begin
    ang_nxt     = ang_r;
    vel_nxt     = vel_r;
    ae_nxt      = ae_r;
    ve_nxt      = ve_r;
    rate_nxt    = rate_r;
    acc_nxt     = acc_r;
    out_nxt     = out_r;
    prev_ae_nxt = prev_ae_r;
    prev_ve_nxt = prev_ve_r;
    vi_nxt      = vi_r;
    if (cmd.load) begin
      ang_nxt = in_measured_angle;
      vel_nxt = in_measured_velocity;
    end
    unique case (cmd.alu_op)
      cavpid_pkg::AO_NONE: ;
      cavpid_pkg::AO_AE:      ae_nxt = cavpid_pkg::sat_sub(cfg.target_angle, ang_r);
      cavpid_pkg::AO_RATE_A: begin
        rate_nxt    = cavpid_pkg::scaled_rate(ae_r, prev_ae_r);
        prev_ae_nxt = ae_r;
      end
      cavpid_pkg::AO_ACC_LD:  acc_nxt = q_r;
      cavpid_pkg::AO_ACC_ADD: acc_nxt = cavpid_pkg::sat_add(acc_r, q_r);
      cavpid_pkg::AO_VE:      ve_nxt = cavpid_pkg::sat_sub(acc_r, vel_r);
      cavpid_pkg::AO_RATE_V: begin
        rate_nxt    = cavpid_pkg::scaled_rate(ve_r, prev_ve_r);
        prev_ve_nxt = ve_r;
      end
      cavpid_pkg::AO_VI:
        vi_nxt = cavpid_pkg::clampsym(cavpid_pkg::sat_add(vi_r, q_r), cfg.integral_limit);
      cavpid_pkg::AO_ADD_VI:  acc_nxt = cavpid_pkg::sat_add(acc_r, vi_r);
      cavpid_pkg::AO_OUT:     out_nxt = cavpid_pkg::clampsym(acc_r, cfg.output_limit);
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ae_r   <= '0;
      prev_ve_r   <= '0;
      vi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      prev_ae_r   <= prev_ae_nxt;
      prev_ve_r   <= prev_ve_nxt;
      vi_r        <= vi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    vel_r  <= vel_nxt;
    ae_r   <= ae_nxt;
    ve_r   <= ve_nxt;
    rate_r <= rate_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    out_r  <= out_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
  end

  assign sts.out_full        = out_valid_r && out_stall;
  assign out_valid           = out_valid_r;
  assign out_torque_command  = out_r;

endmodule

// ----- src/cascaded_angle_velocity_pid.sv -----
// Top level of the cascaded angle/velocity PID: register file, sequencer and datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per control tick: measured
//   angle and angular velocity, signed Q16.16. Output channel (out_valid / out_stall)
//   returns one torque command beat per input beat, signed Q16.16, clamped to
//   +/-output_limit. The cfg_ channel (cfg_valid / cfg_ready, always ready) writes
//   one gain, setpoint or limit per beat by index; write only while the block is idle.
//   The 13-step sequence time-shares one 32x32 multiplier and one saturating adder over
//   the five gain products, so no new input beat is taken until the sequence ends.
//   in_stall is high while a tick is in progress. A finished result waits in the
//   output register; if it is still stalled when the next result is due, the
//   sequencer holds in its last step until the register is free.
//   Reset (rst_n low, synchronous) restores default gains and limits, clears the
//   previous errors and the velocity integral, and empties the output register.
module cascaded_angle_velocity_pid (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [cavpid_pkg::DATA_WIDTH-1:0] in_measured_angle,
  input  logic signed [cavpid_pkg::DATA_WIDTH-1:0] in_measured_velocity,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [cavpid_pkg::DATA_WIDTH-1:0] out_torque_command,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [cavpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cavpid_pkg::DATA_WIDTH-1:0]        cfg_data
);

  cavpid_pkg::cfg_t   cfg_r;
  cavpid_pkg::cfg_t   cfg_nxt;
  cavpid_pkg::cmd_t   cmd;
  cavpid_pkg::sts_t   sts;
  cavpid_pkg::state_t state;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cavpid_pkg::reg_idx_t'(cfg_index))
        cavpid_pkg::REG_ANGLE_KP:       cfg_nxt.angle_kp       = cfg_data;
        cavpid_pkg::REG_ANGLE_KD:       cfg_nxt.angle_kd       = cfg_data;
        cavpid_pkg::REG_VEL_KP:         cfg_nxt.vel_kp         = cfg_data;
        cavpid_pkg::REG_VEL_KI:         cfg_nxt.vel_ki         = cfg_data;
        cavpid_pkg::REG_VEL_KD:         cfg_nxt.vel_kd         = cfg_data;
        cavpid_pkg::REG_TARGET_ANGLE:   cfg_nxt.target_angle   = cfg_data;
        cavpid_pkg::REG_INTEGRAL_LIMIT:
          cfg_nxt.integral_limit = cfg_data[cavpid_pkg::LIM_WIDTH-1:0];
        cavpid_pkg::REG_OUTPUT_LIMIT:
          cfg_nxt.output_limit   = cfg_data[cavpid_pkg::LIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_kp       <= cavpid_pkg::RST_ANGLE_KP;
      cfg_r.angle_kd       <= cavpid_pkg::RST_ANGLE_KD;
      cfg_r.vel_kp         <= cavpid_pkg::RST_VEL_KP;
      cfg_r.vel_ki         <= cavpid_pkg::RST_VEL_KI;
      cfg_r.vel_kd         <= cavpid_pkg::RST_VEL_KD;
      cfg_r.target_angle   <= cavpid_pkg::RST_TARGET_ANGLE;
      cfg_r.integral_limit <= cavpid_pkg::RST_INT_LIMIT;
      cfg_r.output_limit   <= cavpid_pkg::RST_OUT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cavpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  cavpid_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg                  (cfg_r),
    .in_measured_angle    (in_measured_angle),
    .in_measured_velocity (in_measured_velocity),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_torque_command   (out_torque_command)
  );

  // an accepted beat always starts the sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state == cavpid_pkg::ST_AE))
    else $error("accepted beat did not start a tick");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // torque stays inside the output clamp
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_torque_command <= $signed({1'b0, cfg_r.output_limit})) &&
                   (out_torque_command >= -$signed({1'b0, cfg_r.output_limit}))))
    else $error("torque outside output limit");

endmodule

// ----- test/tb_cascaded_angle_velocity_pid.sv -----
// Testbench for the cascaded angle/velocity PID: random gains and ticks checked against a local predictor.
module tb_cascaded_angle_velocity_pid;
  import cavpid_pkg::*;

  localparam longint Q_HI      = 64'sd2147483647;
  localparam longint Q_LO      = -64'sd2147483648;
  localparam int     RUN_LIMIT = 500000;
  localparam int     HOLD_AT   = 300;
  localparam int     HOLD_LEN  = 100;
  localparam int     PHASE_LEN = 240;

  typedef struct {
    data_t angle;
    data_t vel;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  data_t in_measured_angle = '0;
  data_t in_measured_velocity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  data_t out_torque_command;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_WIDTH-1:0] cfg_data = '0;

  cascaded_angle_velocity_pid dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_measured_angle   (in_measured_angle),
    .in_measured_velocity(in_measured_velocity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_torque_command  (out_torque_command),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // controller image
  cfg_t   ctl = '{RST_ANGLE_KP, RST_ANGLE_KD, RST_VEL_KP, RST_VEL_KI, RST_VEL_KD,
                  RST_TARGET_ANGLE, RST_INT_LIMIT, RST_OUT_LIMIT};
  longint last_angle_err = 0;
  longint last_vel_err = 0;
  longint vel_sum = 0;

  tick_t  pending[$];
  data_t  torque_due[$];
  data_t  torque_want;
  logic   calm = 1'b0;
  int     in_gap = 0;
  int     stall_gap = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  int     n_checked = 0;
  int     n_errors = 0;
  int     walk_off = 0;

  function automatic longint clip(input longint v);
    longint r;
    r = v;
    if (v > Q_HI) r = Q_HI;
    else if (v < Q_LO) r = Q_LO;
    return r;
  endfunction

  // Q16.16 product, magnitude rounded half away from zero, saturated
  function automatic longint fx_mul(input longint a, input longint b);
    logic        neg;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] pr;
    logic [63:0] lim;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    pr  = (ua * ub + 64'd32768) >> FRAC_BITS;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (pr > lim) pr = lim;
    return neg ? -longint'(pr) : longint'(pr);
  endfunction

  function automatic longint rate_of(input longint e, input longint last);
    return clip(clip(e - last) * 500);
  endfunction

  function automatic longint clamp_to(input longint v, input lim_t lim);
    longint l;
    longint r;
    l = longint'(lim);
    r = v;
    if (v > l) r = l;
    else if (v < -l) r = -l;
    return r;
  endfunction

  function automatic data_t next_torque(input data_t angle, input data_t vel);
    longint ae;
    longint vt;
    longint ve;
    longint p;
    longint d;
    longint o;
    ae = clip(longint'(ctl.target_angle) - longint'(angle));
    vt = clip(fx_mul(ctl.angle_kp, ae) + fx_mul(ctl.angle_kd, rate_of(ae, last_angle_err)));
    last_angle_err = ae;
    ve = clip(vt - longint'(vel));
    p = fx_mul(ctl.vel_kp, ve);
    vel_sum = clamp_to(clip(vel_sum + fx_mul(ctl.vel_ki, ve)), ctl.integral_limit);
    d = fx_mul(ctl.vel_kd, rate_of(ve, last_vel_err));
    last_vel_err = ve;
    o = clamp_to(clip(clip(p + vel_sum) + d), ctl.output_limit);
    return data_t'(o);
  endfunction

  function automatic data_t extreme_word();
    data_t r;
    case ($urandom_range(0, 4))
      0: r = VMIN;
      1: r = VMAX;
      2: r = '0;
      3: r = -1;
      default: r = 1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic void add_tick(input data_t a, input data_t v);
    tick_t t;
    t.angle = a;
    t.vel   = v;
    pending.push_back(t);
  endfunction

  // mostly a wandering angle near the setpoint, some noise and extremes
  function automatic void add_random_tick();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      walk_off = walk_off + int'($urandom_range(0, 6000)) - 3000;
      if (walk_off > 400000) walk_off = 400000;
      if (walk_off < -400000) walk_off = -400000;
      add_tick(data_t'(clip(longint'(ctl.target_angle) + walk_off)),
               data_t'(rand_span(400000)));
    end else if (pick < 9) begin
      add_tick(data_t'($urandom), data_t'($urandom));
    end else begin
      add_tick(extreme_word(), extreme_word());
    end
  endfunction

  // called just after a rising edge; leaves cfg_valid high
  task automatic put_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_KP:       ctl.angle_kp = val;
      REG_ANGLE_KD:       ctl.angle_kd = val;
      REG_VEL_KP:         ctl.vel_kp = val;
      REG_VEL_KI:         ctl.vel_ki = val;
      REG_VEL_KD:         ctl.vel_kd = val;
      REG_TARGET_ANGLE:   ctl.target_angle = val;
      REG_INTEGRAL_LIMIT: ctl.integral_limit = val[LIM_WIDTH-1:0];
      REG_OUTPUT_LIMIT:   ctl.output_limit = val[LIM_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic program_gains(input logic [31:0] kpa, input logic [31:0] kda,
                               input logic [31:0] kpv, input logic [31:0] kiv,
                               input logic [31:0] kdv, input logic [31:0] tgt,
                               input logic [31:0] il, input logic [31:0] ol);
    put_reg(REG_ANGLE_KP, kpa);
    put_reg(REG_ANGLE_KD, kda);
    put_reg(REG_VEL_KP, kpv);
    put_reg(REG_VEL_KI, kiv);
    put_reg(REG_VEL_KD, kdv);
    put_reg(REG_TARGET_ANGLE, tgt);
    put_reg(REG_INTEGRAL_LIMIT, il);
    put_reg(REG_OUTPUT_LIMIT, ol);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (pending.size() != 0 || in_valid || torque_due.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall)
        torque_due.push_back(next_torque(in_measured_angle, in_measured_velocity));
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          in_gap   <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_measured_angle    <= pending[0].angle;
          in_measured_velocity <= pending[0].vel;
          in_valid             <= 1'b1;
          void'(pending.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (torque_due.size() == 0) begin
          $display("%0t: unexpected torque_command beat %0d", $time, out_torque_command);
          n_errors++;
        end else begin
          torque_want = torque_due.pop_front();
          if (out_torque_command !== torque_want) begin
            $display("%0t: torque_command mismatch, expected %0d, got %0d",
                     $time, torque_want, out_torque_command);
            n_errors++;
          end
          n_checked++;
        end
      end
      // one long hold-off to back the block up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else if (stall_gap != 0) begin
        stall_gap <= stall_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_gap <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < RUN_LIMIT; cyc++) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: extremes and jumps that saturate the derivative
    @(negedge clk);
    add_tick(0, 0);
    add_tick(RST_TARGET_ANGLE, 0);
    add_tick(VMAX, VMAX);
    add_tick(VMIN, VMIN);
    add_tick(VMAX, VMIN);
    add_tick(VMIN, VMAX);
    add_tick(-1, 1);
    add_tick(1, -1);
    add_tick(RST_TARGET_ANGLE, VMAX);
    add_tick(RST_TARGET_ANGLE, VMIN);
    settle();

    // zero integral limit, widest output limit, max outer derivative
    program_gains(RST_ANGLE_KP, VMAX, RST_VEL_KP, VMAX, RST_VEL_KD, RST_TARGET_ANGLE,
                  32'd0, 32'h7FFF_FFFF);
    @(negedge clk);
    add_tick(VMAX, 0);
    add_tick(VMIN, 0);
    add_tick(VMAX, VMAX);
    add_tick(0, VMIN);
    add_tick(RST_TARGET_ANGLE, 0);
    settle();

    // zero output limit, integral limit written with its top bit set
    program_gains(VMIN, VMIN, VMAX, VMIN, VMAX, VMAX, 32'hFFFF_FFFF, 32'd0);
    @(negedge clk);
    add_tick(VMIN, VMAX);
    add_tick(0, 0);
    add_tick(VMAX, -1);
    add_tick(1, 1);
    settle();

    // integral winds up into its clamp, output into its clamp
    program_gains(32'sd65536, 32'd0, 32'sd65536, 32'sd65536, 32'd0, 32'd0,
                  32'd131072, 32'd196608);
    @(negedge clk);
    repeat (4) add_tick(-65536, 0);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 5: program_gains($urandom_range(0, 4 << 16), $urandom_range(0, 3277),
                            $urandom_range(0, 2 << 16), $urandom_range(0, 13107),
                            $urandom_range(0, 6554), rand_span(411775),
                            $urandom_range(1 << 16, 20 << 16),
                            $urandom_range(1 << 16, 10 << 16));
        1, 4: program_gains($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
        2: program_gains(extreme_word(), extreme_word(), extreme_word(), extreme_word(),
                         extreme_word(), extreme_word(),
                         $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF,
                         $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF);
        default: program_gains(rand_span(4 << 16), rand_span(3277), rand_span(2 << 16),
                               rand_span(13107), rand_span(6554), rand_span(411775),
                               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2 << 16),
                               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2 << 16));
      endcase
      if (ph == 5) calm <= 1'b1;
      walk_off = 0;
      @(negedge clk);
      repeat (PHASE_LEN) add_random_tick();
      settle();
    end

    repeat (30) @(posedge clk);
    if (n_errors == 0 && torque_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/cavpid_pkg.sv
src/cavpid_ctrl.sv
src/cavpid_dp.sv
src/cascaded_angle_velocity_pid.sv
test/tb_cascaded_angle_velocity_pid.sv
